[rtl/hybrid_branch_predictor_macros.svh]
// assertion macros for the hybrid branch predictor checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef HYBRID_BRANCH_PREDICTOR_MACROS_SVH
`define HYBRID_BRANCH_PREDICTOR_MACROS_SVH

// property holds at every edge
`define HBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define HBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

[rtl/hbp_pkg.sv]
// hybrid branch predictor package: types, constants, counter and mask functions
// no dependencies
package hbp_pkg;

  localparam int unsigned MAX_GSHARE_BITS_DEF  = 14;
  localparam int unsigned MAX_BIMODAL_BITS_DEF = 14;
  localparam int unsigned MAX_CHOOSER_BITS_DEF = 12;
  localparam int unsigned COUNT_BITS_DEF       = 32;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CTR_W   = 2;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_CHOOSER_BITS,
    REG_GSHARE_BITS,
    REG_HISTORY_BITS,
    REG_BIMODAL_BITS
  } hbp_reg_e;

  typedef enum logic [1:0] {
    MODE_BIMODAL = 2'd0,
    MODE_GSHARE  = 2'd1,
    MODE_HYBRID  = 2'd2
  } hbp_mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } hbp_state_e;

  localparam logic [1:0] RST_MODE         = 2'd0;
  localparam logic [3:0] RST_CHOOSER_BITS = 4'd8;
  localparam logic [3:0] RST_GSHARE_BITS  = 4'd9;
  localparam logic [3:0] RST_HISTORY_BITS = 4'd3;
  localparam logic [3:0] RST_BIMODAL_BITS = 4'd7;

  localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN   = 2'd2;
  localparam logic [CTR_W-1:0] CTR_WEAK_BIMODAL = 2'd1;
  localparam logic [CTR_W-1:0] CTR_MAX          = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN          = 2'd0;

  function automatic logic [CTR_W-1:0] ctr_train(logic [CTR_W-1:0] c, logic up);
    logic [CTR_W-1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

  function automatic logic [31:0] low_mask(logic [4:0] bits);
    return (32'd1 << bits) - 32'd1;
  endfunction

endpackage

[rtl/hbp_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module hbp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hybrid_branch_predictor.sv]
// tournament branch predictor, gshare and bimodal with a chooser table
// result: strobe registered out of the update state entered when a start is accepted
// no new branch is taken while the last one is in its counter read-modify-write
//   through the registered-read table memories (busy during the write back)
// reset: a clearing pass of 2^max(MAX_GSHARE_BITS,MAX_BIMODAL_BITS,MAX_CHOOSER_BITS)
//   table addresses (16384 by default) with busy high; config writes are taken throughout
module hybrid_branch_predictor #(
  parameter int unsigned MAX_GSHARE_BITS  = hbp_pkg::MAX_GSHARE_BITS_DEF,
  parameter int unsigned MAX_BIMODAL_BITS = hbp_pkg::MAX_BIMODAL_BITS_DEF,
  parameter int unsigned MAX_CHOOSER_BITS = hbp_pkg::MAX_CHOOSER_BITS_DEF,
  parameter int unsigned COUNT_BITS       = hbp_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbp_pkg::PADDR_W-1:0] paddr,
  input  logic [hbp_pkg::DATA_W-1:0]  pwdata,
  output logic [hbp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 branch_address_i,
  input  logic                        taken_i,
  output logic                        result_valid_o,
  output logic                        predicted_taken_o,
  output logic                        mispredicted_o,
  output logic                        used_gshare_o,
  output logic [31:0]                 predictions_so_far_o,
  output logic [31:0]                 mispredictions_so_far_o
);
  import hbp_pkg::*;

  localparam int unsigned GAW = MAX_GSHARE_BITS;
  localparam int unsigned BAW = MAX_BIMODAL_BITS;
  localparam int unsigned CAW = MAX_CHOOSER_BITS;
  localparam int unsigned HW  = MAX_GSHARE_BITS;
  localparam int unsigned GB_W = (GAW > BAW) ? GAW : BAW;
  localparam int unsigned CLR_W = (GB_W > CAW) ? GB_W : CAW;

  // config registers
  logic [1:0] mode_q;
  logic [3:0] chooser_bits_q, gshare_bits_q, history_bits_q, bimodal_bits_q;
  logic       cfg_wr;
  hbp_reg_e   cfg_idx;

  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = hbp_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= RST_MODE;
      chooser_bits_q <= RST_CHOOSER_BITS;
      gshare_bits_q  <= RST_GSHARE_BITS;
      history_bits_q <= RST_HISTORY_BITS;
      bimodal_bits_q <= RST_BIMODAL_BITS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:         mode_q         <= pwdata[1:0];
        REG_CHOOSER_BITS: chooser_bits_q <= pwdata[3:0];
        REG_GSHARE_BITS:  gshare_bits_q  <= pwdata[3:0];
        REG_HISTORY_BITS: history_bits_q <= pwdata[3:0];
        REG_BIMODAL_BITS: bimodal_bits_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:         prdata = DATA_W'(mode_q);
      REG_CHOOSER_BITS: prdata = DATA_W'(chooser_bits_q);
      REG_GSHARE_BITS:  prdata = DATA_W'(gshare_bits_q);
      REG_HISTORY_BITS: prdata = DATA_W'(history_bits_q);
      REG_BIMODAL_BITS: prdata = DATA_W'(bimodal_bits_q);
      default:          prdata = '0;
    endcase
  end

  // effective widths
  logic [4:0] m_w, n_w, mb_w, kb_w, mn_w;
  logic [31:0] hmask;

  always_comb begin
    m_w  = (5'(gshare_bits_q) > 5'(MAX_GSHARE_BITS)) ? 5'(MAX_GSHARE_BITS)
                                                     : 5'(gshare_bits_q);
    n_w  = (5'(history_bits_q) > m_w) ? m_w : 5'(history_bits_q);
    mb_w = (5'(bimodal_bits_q) > 5'(MAX_BIMODAL_BITS)) ? 5'(MAX_BIMODAL_BITS)
                                                       : 5'(bimodal_bits_q);
    kb_w = (5'(chooser_bits_q) > 5'(MAX_CHOOSER_BITS)) ? 5'(MAX_CHOOSER_BITS)
                                                       : 5'(chooser_bits_q);
    mn_w = m_w - n_w;
    hmask = low_mask(n_w);
  end

  // state
  hbp_state_e state_q, state_d;
  logic [CLR_W-1:0] clr_q;
  logic [HW-1:0] hist_q, hist_d;
  logic [COUNT_BITS-1:0] pcount_q, mcount_q;
  logic taken_q;
  logic [GAW-1:0] ig_q;
  logic [BAW-1:0] ib_q;
  logic [CAW-1:0] ic_q;
  logic accept;

  assign accept = start & (state_q == ST_IDLE);

  // index computation for the incoming branch
  logic [31:0] pc, ib32, ig32, ic32, upper;

  always_comb begin
    pc    = 32'(branch_address_i[31:2]);
    ib32  = pc & low_mask(mb_w);
    upper = (32'(hist_q) & hmask) ^ ((branch_address_i >> (5'd2 + mn_w)) & hmask);
    ig32  = ((upper << mn_w) | (pc & low_mask(mn_w))) & low_mask(m_w);
    ic32  = pc & low_mask(kb_w);
  end

  // table memories
  logic             b_we, g_we, c_we;
  logic [BAW-1:0]   b_waddr;
  logic [GAW-1:0]   g_waddr;
  logic [CAW-1:0]   c_waddr;
  logic [CTR_W-1:0] b_wdata, g_wdata, c_wdata, b_rd, g_rd, c_rd;

  hbp_ram #(.WIDTH(CTR_W), .DEPTH(2 ** BAW)) u_bimodal_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (ib32[BAW-1:0]),
    .rdata_o (b_rd)
  );

  hbp_ram #(.WIDTH(CTR_W), .DEPTH(2 ** GAW)) u_gshare_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (ig32[GAW-1:0]),
    .rdata_o (g_rd)
  );

  hbp_ram #(.WIDTH(CTR_W), .DEPTH(2 ** CAW)) u_chooser_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (ic32[CAW-1:0]),
    .rdata_o (c_rd)
  );

  // prediction and training
  logic pb, pg, hybrid, used_g, pred, miss;

  always_comb begin
    pb     = b_rd[1];
    pg     = g_rd[1];
    hybrid = mode_q[1];
    used_g = hybrid & c_rd[1];
    if (mode_q == MODE_BIMODAL) begin
      pred = pb;
    end else if (mode_q == MODE_GSHARE) begin
      pred = pg;
    end else begin
      pred = used_g ? pg : pb;
    end
    miss = pred ^ taken_q;
  end

  always_comb begin
    hist_d = hist_q;
    if ((mode_q != MODE_BIMODAL) && (n_w != 5'd0)) begin
      hist_d = HW'(((32'(taken_q) << (n_w - 5'd1)) | ((32'(hist_q) & hmask) >> 1)) & hmask);
    end
  end

  // fsm next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (&clr_q) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy    = 1'b1;
    b_we    = 1'b0;
    g_we    = 1'b0;
    c_we    = 1'b0;
    b_waddr = ib_q;
    g_waddr = ig_q;
    c_waddr = ic_q;
    b_wdata = ctr_train(b_rd, taken_q);
    g_wdata = ctr_train(g_rd, taken_q);
    c_wdata = ctr_train(c_rd, pg == taken_q);
    case (state_q)
      ST_CLEAR: begin
        b_we    = 1'b1;
        g_we    = 1'b1;
        c_we    = 1'b1;
        b_waddr = clr_q[BAW-1:0];
        g_waddr = clr_q[GAW-1:0];
        c_waddr = clr_q[CAW-1:0];
        b_wdata = CTR_WEAK_TAKEN;
        g_wdata = CTR_WEAK_TAKEN;
        c_wdata = CTR_WEAK_BIMODAL;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_UPDATE: begin
        b_we = (mode_q == MODE_BIMODAL) | (hybrid & ~used_g);
        g_we = (mode_q == MODE_GSHARE) | (hybrid & used_g);
        c_we = hybrid & (pg != pb);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      hist_q         <= '0;
      pcount_q       <= '0;
      mcount_q       <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= (state_q == ST_UPDATE);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + CLR_W'(1);
      end
      if (state_q == ST_UPDATE) begin
        hist_q <= hist_d;
        if (pcount_q != '1) begin
          pcount_q <= pcount_q + COUNT_BITS'(1);
        end
        if (miss && (mcount_q != '1)) begin
          mcount_q <= mcount_q + COUNT_BITS'(1);
        end
      end
    end
  end

  logic [COUNT_BITS-1:0] pcount_next, mcount_next;

  assign pcount_next = (pcount_q == '1) ? pcount_q : pcount_q + COUNT_BITS'(1);
  assign mcount_next = (miss && (mcount_q != '1)) ? mcount_q + COUNT_BITS'(1) : mcount_q;

  // transaction capture and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      taken_q <= taken_i;
      ib_q    <= ib32[BAW-1:0];
      ig_q    <= ig32[GAW-1:0];
      ic_q    <= ic32[CAW-1:0];
    end
    if (state_q == ST_UPDATE) begin
      predicted_taken_o       <= pred;
      mispredicted_o          <= miss;
      used_gshare_o           <= used_g;
      predictions_so_far_o    <= 32'(pcount_next);
      mispredictions_so_far_o <= 32'(mcount_next);
    end
  end

endmodule

[rtl/hbp_checker.sv]
// port-level checker for the hybrid branch predictor, bound to the top level
// depends on hybrid_branch_predictor_macros.svh
`include "hybrid_branch_predictor_macros.svh"

module hbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic taken_i,
  input logic result_valid_o,
  input logic predicted_taken_o,
  input logic mispredicted_o
);

  `HBP_ASSERT(a_accept_gives_result, start && !busy |-> ##2 result_valid_o, "missing result")
  `HBP_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o, "result repeated")
  `HBP_ASSERT(a_idle_at_result, result_valid_o |-> !busy, "busy while result shown")
  `HBP_ASSERT(a_miss_flag, result_valid_o |-> (mispredicted_o == (predicted_taken_o ^ $past(taken_i, 2))), "bad mispredict flag")

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (.*);
